@@ src/ffdsp_pkg.sv @@
package ffdsp_pkg;

  // field widths fixed by the interface
  localparam int TS_W    = 16;
  localparam int TICKS_W = 12;
  localparam int IDX_W   = 10;

  // register map
  localparam logic CFG_IDX_NOMINAL = 1'b0;
  localparam logic [TICKS_W-1:0] NOM_TICKS_RESET = 12'd144;

  // derived limits, nom = t << 16:
  //   nom*11/10 = 72089*t + floor(3t/5)
  //   nom*9/10  = 58982*t + floor(2t/5)
  //   nom/800   = 81*t    + floor(23t/25)
  // each floor term is a reciprocal multiply and a right shift
  localparam logic [35:0] PMAX_INT   = 36'd72089;
  localparam logic [35:0] PMAX_RECIP = 36'd78645;   // 3 * ceil(2^17/5)
  localparam logic [35:0] PMIN_INT   = 36'd58982;
  localparam logic [35:0] PMIN_RECIP = 36'd52430;   // 2 * ceil(2^17/5)
  localparam int          FIFTH_SH   = 17;
  localparam logic [35:0] STEP_INT   = 36'd81;
  localparam logic [35:0] STEP_RECIP = 36'd3858779; // 23 * ceil(2^22/25)
  localparam int          STEP_SH    = 22;

  // trend logic
  localparam logic [3:0] TREND_MIN  = 4'd5;
  localparam logic [3:0] TREND_SKEW = 4'd2;

  typedef struct packed {
    logic [TS_W-1:0] edge_time;
    logic            flush;
  } edge_word_t;

  typedef struct packed {
    logic [31:0]      data_word;
    logic [IDX_W-1:0] word_index;
    logic [31:0]      bit_total;
    logic             is_final;
    logic             zero_overflow;
    logic             last;
  } res_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_RUNT,
    ST_RANGE,
    ST_DIV,
    ST_PHASE,
    ST_PERIOD,
    ST_SHIFT,
    ST_FLUSH
  } sep_state_t;

endpackage

@@ src/floppy_flux_data_separator_pll.sv @@
// digital pll data separator for floppy flux streams. each input word is the
// 16-bit timestamp of one flux transition (or a flush request); the pll runs
// in 16.16 fixed point time and turns the transitions into bitcells, packed
// msb-first into 32-bit result words. an edge closer than one cell period to
// the current cell start is dropped as a runt. the empty cells passed become
// zeros (at most MAX_ZERO_RUN per edge, beyond which zero_overflow is raised
// on the next result) and the edge cell becomes a one. the phase is pulled by
// period/8 when the edge lies outside 3/8..5/8 of the cell, and after five
// pulls a one-sided trend nudges the period by nominal/800 within +-10% of
// nominal. a flush emits the partial word left-justified with is_final set
// and restarts the stream. the edge subtractions and the division share one
// 33-bit subtractor under a small sequencer, and a word is taken only while
// the sequencer is idle. an edge steps through the distance, runt and range
// states, and a runt goes back to idle there. a gap longer than two periods
// then runs a bit-serial restoring division that counts the empty cells, and
// every kept edge goes on through the phase, period and shift states. bits
// are shifted one per cycle, and the shifter waits while a completed word
// cannot be handed to the result register. writing nominal_period_ticks
// restarts the stream from the new nominal period.
module floppy_flux_data_separator_pll
  import ffdsp_pkg::*;
#(
  parameter int BUF_WORDS    = 1024,
  parameter int MAX_ZERO_RUN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // flux edge words
  input  logic        edge_valid,
  output logic        edge_ready,
  input  edge_word_t  edge_word,
  // recovered data words
  output logic        res_valid,
  input  logic        res_ready,
  output res_word_t   res_word,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
  localparam int ZW = $clog2(MAX_ZERO_RUN + 1);

  function automatic logic [31:0] nom_of(input logic [TICKS_W-1:0] t);
    logic [31:0] n;
    n = {4'd0, t, 16'd0};
    if (t == '0) begin
      n = 32'h0001_0000;
    end
    return n;
  endfunction

  sep_state_t state, state_next;

  // configuration
  logic [TICKS_W-1:0] nom_ticks;
  logic [TICKS_W-1:0] t_eff;
  logic               cfg_wr;

  // derived limits, two-stage constant multiply
  logic [35:0] pmax_a, pmax_b, pmin_a, pmin_b, step_a, step_b;
  logic [31:0] pmax, pmin, step;

  // pll and packer state
  logic [31:0]   cell_period;
  logic [31:0]   prev_cell_start;
  logic [2:0]    phase_inc_count;
  logic [2:0]    phase_dec_count;
  logic [31:0]   bit_shift_reg;
  logic [31:0]   bit_counter;
  logic          overflow_seen;
  logic [IW-1:0] word_idx;

  // per-edge working registers
  logic [TS_W-1:0] edge_ts;
  logic [31:0]     acc;        // distance, then cell offset d
  logic [31:0]     quo;        // dividend, then empty cell count
  logic [31:0]     rem;
  logic [4:0]      div_cnt;
  logic [ZW-1:0]   zeros;
  logic            phase_up;
  logic            phase_dn;

  // shared subtractor
  logic [32:0] alu_a, alu_b;
  logic [33:0] alu_diff;
  logic        alu_borrow;

  logic [31:0] edge_fx;
  logic        out_free;
  logic        word_done;
  logic        push_go;
  logic        flush_go;
  logic        reinit;
  logic        push_bit;
  logic [31:0] shift_next;
  logic [IW-1:0] idx_next;
  logic [IW+IDX_W-1:0] idx_ext;
  logic [IW+IDX_W-1:0] idx_flush_ext;
  logic [31:0] div_rem_next;
  logic [33:0] thr3_sum;
  logic [34:0] thr5_sum;
  logic [31:0] thr3, thr5;
  logic [3:0]  cnt_sum;
  logic [32:0] period_up;
  logic [4:0]  flush_sh;

  assign edge_fx   = {edge_ts, 16'd0};
  assign t_eff     = (nom_ticks == '0) ? TICKS_W'(1) : nom_ticks;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == CFG_IDX_NOMINAL);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == CFG_IDX_NOMINAL) ? {20'd0, nom_ticks} : 32'd0;

  assign out_free  = !res_valid || res_ready;
  assign word_done = (bit_counter[4:0] == 5'd31);
  assign push_bit  = (zeros == '0);

  // operand select for the one subtractor
  always_comb begin
    alu_a = {1'b0, edge_fx};
    alu_b = {1'b0, prev_cell_start};
    case (state)
      ST_RUNT: begin
        alu_a = {1'b0, acc};
        alu_b = {1'b0, cell_period};
      end
      ST_RANGE: begin
        alu_a = {1'b0, acc - 32'd1};
        alu_b = {1'b0, cell_period};
      end
      ST_DIV: begin
        alu_a = {rem, quo[31]};
        alu_b = {1'b0, cell_period};
      end
      ST_PHASE: begin
        alu_a = {1'b0, edge_fx};
        alu_b = {1'b0, acc};
      end
      default: begin
        alu_a = {1'b0, edge_fx};
        alu_b = {1'b0, prev_cell_start};
      end
    endcase
  end

  assign alu_diff     = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow   = alu_diff[33];
  assign div_rem_next = alu_borrow ? alu_a[31:0] : alu_diff[31:0];

  // phase window: 3/8 and 5/8 of the period, no wrap
  assign thr3_sum = {2'd0, cell_period} + {1'b0, cell_period, 1'b0};
  assign thr5_sum = {3'd0, cell_period} + {1'b0, cell_period, 2'd0};
  assign thr3     = 32'(thr3_sum >> 3);
  assign thr5     = 32'(thr5_sum >> 3);

  assign cnt_sum   = {1'b0, phase_inc_count} + {1'b0, phase_dec_count};
  assign period_up = {1'b0, cell_period} + {1'b0, step};

  assign shift_next    = {bit_shift_reg[30:0], push_bit};
  assign idx_ext       = {{IDX_W{1'b0}}, word_idx};
  assign idx_flush_ext = idx_ext;
  assign flush_sh      = 5'd0 - bit_counter[4:0];

  // word index counts bit_counter/32 modulo BUF_WORDS, rewinding when
  // bit_counter itself wraps
  always_comb begin
    idx_next = word_idx;
    if (bit_counter[31:5] == '1) begin
      idx_next = '0;
    end else if (word_idx == IW'(BUF_WORDS - 1)) begin
      idx_next = '0;
    end else begin
      idx_next = word_idx + IW'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    edge_ready = 1'b0;
    push_go    = 1'b0;
    flush_go   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        edge_ready = 1'b1;
        if (edge_valid) begin
          state_next = edge_word.flush ? ST_FLUSH : ST_DIST;
        end
      end
      ST_DIST: begin
        state_next = ST_RUNT;
      end
      ST_RUNT: begin
        // closer than one period to the cell start: runt, dropped
        state_next = alu_borrow ? ST_IDLE : ST_RANGE;
      end
      ST_RANGE: begin
        state_next = ((acc != 32'd0) && !alu_borrow) ? ST_DIV : ST_PHASE;
      end
      ST_DIV: begin
        if (div_cnt == 5'd31) begin
          state_next = ST_PHASE;
        end
      end
      ST_PHASE: begin
        state_next = ST_PERIOD;
      end
      ST_PERIOD: begin
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        // hold while a finished word has nowhere to go
        push_go = !word_done || out_free;
        if (push_go && push_bit) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        flush_go = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // derived limits follow the register through the product registers and the
  // limit registers; the first use in the period step lies well past that after any write
  always_ff @(posedge clk) begin
    pmax_a <= 36'(t_eff) * PMAX_INT;
    pmax_b <= 36'(t_eff) * PMAX_RECIP;
    pmin_a <= 36'(t_eff) * PMIN_INT;
    pmin_b <= 36'(t_eff) * PMIN_RECIP;
    step_a <= 36'(t_eff) * STEP_INT;
    step_b <= 36'(t_eff) * STEP_RECIP;
    pmax   <= 32'(pmax_a + (pmax_b >> FIFTH_SH));
    pmin   <= 32'(pmin_a + (pmin_b >> FIFTH_SH));
    step   <= 32'(step_a + (step_b >> STEP_SH));
  end

  assign reinit = cfg_wr || flush_go;

  // pll and packer state
  always_ff @(posedge clk) begin
    if (rst) begin
      nom_ticks       <= NOM_TICKS_RESET;
      cell_period     <= nom_of(NOM_TICKS_RESET);
      prev_cell_start <= 32'd0 - nom_of(NOM_TICKS_RESET);
      phase_inc_count <= '0;
      phase_dec_count <= '0;
      bit_shift_reg   <= '1;
      bit_counter     <= '0;
      overflow_seen   <= 1'b0;
      word_idx        <= '0;
    end else if (reinit) begin
      if (cfg_wr) begin
        nom_ticks       <= pwdata[TICKS_W-1:0];
        cell_period     <= nom_of(pwdata[TICKS_W-1:0]);
        prev_cell_start <= 32'd0 - nom_of(pwdata[TICKS_W-1:0]);
      end else begin
        cell_period     <= nom_of(nom_ticks);
        prev_cell_start <= 32'd0 - nom_of(nom_ticks);
      end
      phase_inc_count <= '0;
      phase_dec_count <= '0;
      bit_shift_reg   <= '1;
      bit_counter     <= '0;
      overflow_seen   <= 1'b0;
      word_idx        <= '0;
    end else begin
      case (state)
        ST_PHASE: begin
          // cell start of the edge cell, before the phase pull
          prev_cell_start <= alu_diff[31:0];
          if (acc < thr3) begin
            phase_dec_count <= phase_dec_count + 3'd1;
          end else if (acc > thr5) begin
            phase_inc_count <= phase_inc_count + 3'd1;
          end
          if (quo > 32'(MAX_ZERO_RUN)) begin
            overflow_seen <= 1'b1;
          end
        end
        ST_PERIOD: begin
          if (phase_up) begin
            prev_cell_start <= prev_cell_start + (cell_period >> 3);
          end else if (phase_dn) begin
            prev_cell_start <= prev_cell_start - (cell_period >> 3);
          end
          if (cnt_sum >= TREND_MIN) begin
            if ({1'b0, phase_inc_count} > {1'b0, phase_dec_count} + TREND_SKEW) begin
              cell_period <= (period_up > {1'b0, pmax}) ? pmax : period_up[31:0];
            end else if ({1'b0, phase_dec_count} > {1'b0, phase_inc_count} + TREND_SKEW) begin
              if ((cell_period < step) || (cell_period - step < pmin)) begin
                cell_period <= pmin;
              end else begin
                cell_period <= cell_period - step;
              end
            end
            phase_inc_count <= '0;
            phase_dec_count <= '0;
          end
        end
        ST_SHIFT: begin
          if (push_go) begin
            bit_shift_reg <= shift_next;
            bit_counter   <= bit_counter + 32'd1;
            if (word_done) begin
              word_idx      <= idx_next;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-edge working registers
  always_ff @(posedge clk) begin
    if (edge_ready && edge_valid) begin
      edge_ts <= edge_word.edge_time;
    end
    case (state)
      ST_DIST: begin
        acc <= alu_diff[31:0];
      end
      ST_RUNT: begin
        acc <= alu_diff[31:0];
      end
      ST_RANGE: begin
        // quotient (d-1)/p counts the empty cells when d > p
        quo     <= ((acc != 32'd0) && !alu_borrow) ? alu_a[31:0] : 32'd0;
        rem     <= 32'd0;
        div_cnt <= 5'd0;
      end
      ST_DIV: begin
        rem     <= div_rem_next;
        quo     <= {quo[30:0], !alu_borrow};
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'd31) begin
          acc <= div_rem_next + 32'd1;
        end
      end
      ST_PHASE: begin
        phase_dn <= (acc < thr3);
        phase_up <= !(acc < thr3) && (acc > thr5);
        zeros    <= (quo > 32'(MAX_ZERO_RUN)) ? ZW'(MAX_ZERO_RUN) : quo[ZW-1:0];
      end
      ST_SHIFT: begin
        if (push_go && !push_bit) begin
          zeros <= zeros - ZW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((push_go && word_done) || flush_go) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flush_go) begin
      res_word.data_word     <= bit_shift_reg << flush_sh;
      res_word.word_index    <= idx_flush_ext[IDX_W-1:0];
      res_word.bit_total     <= bit_counter;
      res_word.is_final      <= 1'b1;
      res_word.zero_overflow <= overflow_seen;
      res_word.last          <= 1'b1;
    end else if (push_go && word_done) begin
      res_word.data_word     <= shift_next;
      res_word.word_index    <= idx_ext[IDX_W-1:0];
      res_word.bit_total     <= bit_counter + 32'd1;
      res_word.is_final      <= 1'b0;
      res_word.zero_overflow <= overflow_seen;
      // a later word follows only if 32 or more pushes remain
      res_word.last          <= push_bit || (zeros < ZW'(32));
    end
  end

`ifndef SYNTHESIS
  // the zero run counter never exceeds the cap
  a_zero_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (zeros <= ZW'(MAX_ZERO_RUN)))
    else $error("zero run counter above cap");

  // a flush result always closes its item
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.is_final) |-> res_word.last)
    else $error("final word without last");

  // a completed word always lands on a 32-bit boundary
  a_word_align: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_word.is_final) |-> (res_word.bit_total[4:0] == 5'd0))
    else $error("completed word not aligned");

  // a new result is never loaded over one that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !(push_go && word_done) && !flush_go)
    else $error("result register overrun");
`endif

endmodule
